[sv/tacs_pkg.sv]
// ----------------------------------------------------------------------------
// tacs_pkg: shared types and constants for the touch calibration scale unit
// Holds the payload structs, register indexes and status codes.
// ----------------------------------------------------------------------------
package tacs_pkg;

    typedef struct packed {
        logic [15:0] target_height;
        logic [15:0] target_width;
        logic [11:0] raw_y;
        logic [11:0] raw_x;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] cal_y;
        logic signed [31:0] cal_x;
    } t_out_word;

    typedef enum logic [2:0] {
        REG_CXX    = 3'd0,
        REG_CXY    = 3'd1,
        REG_OFFX   = 3'd2,
        REG_CYX    = 3'd3,
        REG_CYY    = 3'd4,
        REG_OFFY   = 3'd5,
        REG_DIV    = 3'd6,
        REG_CALRES = 3'd7
    } t_reg_idx;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_DIVZERO = 2'd1;
    localparam logic [1:0] STATUS_CALZERO = 2'd2;

    localparam int unsigned DIV_STAGES = 32;

endpackage

[sv/tacs_div_pipe.sv]
// ----------------------------------------------------------------------------
// tacs_div_pipe: pipelined signed 32-bit division, truncating toward zero
// One quotient bit per stage, an item enters in every enabled cycle.
// ----------------------------------------------------------------------------
module tacs_div_pipe (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo
);
    import tacs_pkg::*;

    // Per-stage state: partial remainder, shifted numerator/quotient, divisor.
    logic [31:0] r_rem [DIV_STAGES+1];
    logic [31:0] r_nq  [DIV_STAGES+1];
    logic [31:0] r_dm  [DIV_STAGES+1];
    logic        r_neg [DIV_STAGES+1];

    logic [31:0] n_nm, n_dm;

    always_comb begin
        n_nm = i_num[31] ? (32'd0 - i_num) : i_num;
        n_dm = i_den[31] ? (32'd0 - i_den) : i_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_nq[0]  <= n_nm;
            r_dm[0]  <= n_dm;
            r_neg[0] <= i_num[31] ^ i_den[31];
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [32:0] n_trial;
        logic [32:0] n_diff;
        always_comb begin
            n_trial = {r_rem[s], r_nq[s][31]};
            n_diff  = n_trial - {1'b0, r_dm[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_diff[32] ? n_trial[31:0] : n_diff[31:0];
                r_nq[s+1]  <= {r_nq[s][30:0], ~n_diff[32]};
                r_dm[s+1]  <= r_dm[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    assign o_quo = r_neg[DIV_STAGES] ? (32'd0 - r_nq[DIV_STAGES]) : r_nq[DIV_STAGES];

endmodule

[sv/touch_affine_calibrate_scale_unit.sv]
// ----------------------------------------------------------------------------
// touch_affine_calibrate_scale_unit: affine touch calibration with rescaling
// Maps raw touch samples through six coefficients and a divisor, then scales.
// ----------------------------------------------------------------------------
// Usage: write the eight calibration registers over the config channel
// (i_cfg_valid/o_cfg_ready, index and data) while the unit is idle; indexes
// beyond the list are ignored. Raw samples enter on i_in_valid/o_in_ready as
// one word each and one result word leaves on o_out_valid/i_out_ready.
// The datapath is one long pipeline: products, sum, a 32-stage bit-per-stage
// divider for the calibration divide, products by the target size, and a
// second 32-stage divider for the rescale. A word can enter every cycle while the
// output is not stalled. The pipeline holds 70 stages, set by the two divider
// pipelines with their setup stages. The whole pipeline advances only when
// its last stage is empty or being taken, so a stalled receiver freezes every
// stage and nothing is lost.
// Reset clears the registers to zero and empties the pipeline; zero divisor
// gives status 1 and zero calibration size gives status 2, both with zero
// coordinates.
// ----------------------------------------------------------------------------
module touch_affine_calibrate_scale_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tacs_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tacs_pkg::t_out_word  o_out_word
);
    import tacs_pkg::*;

    localparam int unsigned LAT = 2 * DIV_STAGES + 6;

    logic [31:0] r_cfg [8];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_cfg[k] <= '0;
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Valid bits and side data that ride along with the divider pipelines.
    logic          r_vld [LAT];
    logic [1:0]    r_st  [LAT];
    logic [15:0]   r_tw  [LAT];
    logic [15:0]   r_th  [LAT];
    logic          en;

    assign en          = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];

    logic [1:0] n_st0;
    always_comb begin
        priority if (r_cfg[REG_DIV] == 32'd0) n_st0 = STATUS_DIVZERO;
        else if (r_cfg[REG_CALRES][15:0] == 16'd0 || r_cfg[REG_CALRES][31:16] == 16'd0)
            n_st0 = STATUS_CALZERO;
        else n_st0 = STATUS_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= n_st0;
            r_tw[0] <= i_in_word.target_width;
            r_th[0] <= i_in_word.target_height;
            for (int k = 1; k < LAT; k++) begin
                r_st[k] <= r_st[k-1];
                r_tw[k] <= r_tw[k-1];
                r_th[k] <= r_th[k-1];
            end
        end
    end

    // Stage 0: four products. Stage 1: the two sums.
    logic [31:0] r_pxx, r_pxy, r_pyx, r_pyy, r_nx, r_ny;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxx <= r_cfg[REG_CXX] * {20'd0, i_in_word.raw_x};
            r_pxy <= r_cfg[REG_CXY] * {20'd0, i_in_word.raw_y};
            r_pyx <= r_cfg[REG_CYX] * {20'd0, i_in_word.raw_x};
            r_pyy <= r_cfg[REG_CYY] * {20'd0, i_in_word.raw_y};
            r_nx  <= r_cfg[REG_OFFX] + r_pxx + r_pxy;
            r_ny  <= r_cfg[REG_OFFY] + r_pyx + r_pyy;
        end
    end

    // Stages 2..34: calibration divide (stage 2 sets up, 32 bit stages).
    logic [31:0] q1x, q1y;
    tacs_div_pipe u_div1x (.i_clk, .i_en(en), .i_num(r_nx), .i_den(r_cfg[REG_DIV]),
                           .o_quo(q1x));
    tacs_div_pipe u_div1y (.i_clk, .i_en(en), .i_num(r_ny), .i_den(r_cfg[REG_DIV]),
                           .o_quo(q1y));

    // Quotients sit at stage index DIV_STAGES+2; register the products after it.
    logic [31:0] r_sx, r_sy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx <= q1x * {16'd0, r_tw[DIV_STAGES+2]};
            r_sy <= q1y * {16'd0, r_th[DIV_STAGES+2]};
        end
    end

    logic [31:0] q2x, q2y;
    tacs_div_pipe u_div2x (.i_clk, .i_en(en), .i_num(r_sx),
                           .i_den({16'd0, r_cfg[REG_CALRES][15:0]}), .o_quo(q2x));
    tacs_div_pipe u_div2y (.i_clk, .i_en(en), .i_num(r_sy),
                           .i_den({16'd0, r_cfg[REG_CALRES][31:16]}), .o_quo(q2y));

    logic [31:0] r_ox, r_oy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox <= q2x;
            r_oy <= q2y;
        end
    end

    always_comb begin
        o_out_word.status = r_st[LAT-1];
        o_out_word.cal_x  = (r_st[LAT-1] == STATUS_OK) ? r_ox : 32'd0;
        o_out_word.cal_y  = (r_st[LAT-1] == STATUS_OK) ? r_oy : 32'd0;
    end

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed under stall");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != STATUS_OK |->
        o_out_word.cal_x == 32'd0 && o_out_word.cal_y == 32'd0)
        else $error("error word carries coordinates");
`endif

endmodule

[tb/tacs_checker.sv]
// ----------------------------------------------------------------------------
// tacs_checker: result predictor and scoreboard for the calibration scale unit
// Watches the config, input and output channels, computes the expected word
// for every accepted sample and compares it with each delivered result.
// ----------------------------------------------------------------------------
module tacs_checker
    import tacs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_word  i_out_word,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] cal_regs [8];
    t_out_word   expected_words [$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_words.size();

    // Signed divide truncating toward zero; a most-negative by minus-one wraps.
    function automatic logic [31:0] div_toward_zero(logic [31:0] n, logic [31:0] d);
        logic [31:0] nm;
        logic [31:0] dm;
        logic [31:0] q;
        nm = n[31] ? -n : n;
        dm = d[31] ? -d : d;
        q  = nm / dm;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic t_out_word calibrate_sample(t_in_word w);
        t_out_word   r;
        logic [31:0] div;
        logic [31:0] cw;
        logic [31:0] ch;
        logic [31:0] nx;
        logic [31:0] ny;
        div = cal_regs[REG_DIV];
        cw  = {16'd0, cal_regs[REG_CALRES][15:0]};
        ch  = {16'd0, cal_regs[REG_CALRES][31:16]};
        r   = '0;
        if (div == 0) begin
            r.status = STATUS_DIVZERO;
        end else if (cw == 0 || ch == 0) begin
            r.status = STATUS_CALZERO;
        end else begin
            nx = cal_regs[REG_OFFX] + cal_regs[REG_CXX] * {20'd0, w.raw_x}
                 + cal_regs[REG_CXY] * {20'd0, w.raw_y};
            ny = cal_regs[REG_OFFY] + cal_regs[REG_CYX] * {20'd0, w.raw_x}
                 + cal_regs[REG_CYY] * {20'd0, w.raw_y};
            nx = div_toward_zero(nx, div);
            ny = div_toward_zero(ny, div);
            r.cal_x  = div_toward_zero(nx * {16'd0, w.target_width}, cw);
            r.cal_y  = div_toward_zero(ny * {16'd0, w.target_height}, ch);
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            foreach (cal_regs[i]) cal_regs[i] = '0;
            expected_words.delete();
            fail_count = 0;
        end else begin
            // A word taken on this edge was computed with the registers as they stood.
            if (i_in_valid && i_in_ready) begin
                expected_words.push_back(calibrate_sample(i_in_word));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cal_regs[i_cfg_index] = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", i_out_word.cal_x, 32'd0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_word.cal_x !== want.cal_x)
                        report_mismatch("cal_x", i_out_word.cal_x, want.cal_x);
                    if (i_out_word.cal_y !== want.cal_y)
                        report_mismatch("cal_y", i_out_word.cal_y, want.cal_y);
                    if (i_out_word.status !== want.status)
                        report_mismatch("status", {30'd0, i_out_word.status},
                                        {30'd0, want.status});
                end
            end
        end
    end
endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench top for the touch calibration scale unit
// Drives register settings and raw samples with random gaps and receiver
// stalls, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
    import tacs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY_CYCLES = 70;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_word   out_word;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;

    always #10 clk = ~clk;

    touch_affine_calibrate_scale_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    tacs_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The watchdog counts cycles in which no channel moves a word.
    always @(posedge clk) begin
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver stalls on its own pattern: runs of full readiness, runs of
    // random stalls, and a long hold-off while the sender keeps offering.
    initial begin : receiver
        int mode;
        int run;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            run  = $urandom_range(5, 80);
            repeat (run) begin
                @(negedge clk);
                if (hold_off)
                    out_ready <= 1'b0;
                else if (mode == 0)
                    out_ready <= 1'b1;
                else if (mode == 1)
                    out_ready <= ($urandom_range(0, 3) != 0);
                else
                    out_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic write_register(t_reg_idx idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send one sample; valid stays high across back-to-back words in a burst.
    task automatic send_sample(t_in_word w, bit keep_valid);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (!keep_valid)
            in_valid <= 1'b0;
    endtask

    task automatic send_burst(int count, bit extreme);
        int gap;
        t_in_word w;
        for (int i = 0; i < count; i++) begin
            w.raw_x = $urandom;
            w.raw_y = $urandom;
            w.target_width  = $urandom;
            w.target_height = $urandom;
            if (extreme && $urandom_range(0, 3) == 0) begin
                w.raw_x = $urandom_range(0, 1) ? 12'hfff : 12'h000;
                w.raw_y = $urandom_range(0, 1) ? 12'hfff : 12'h000;
                w.target_width  = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                w.target_height = $urandom_range(0, 1) ? 16'hffff : 16'h0001;
            end
            send_sample(w, i != count - 1);
        end
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        repeat (gap) @(negedge clk);
    endtask

    // Registers are written only once every expected word has come home.
    task automatic drain;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY_CYCLES + 4) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_coef(int style);
        case (style)
            0: return $urandom_range(0, 2000) - 1000;
            1: return $urandom;
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    task automatic load_setting(int style);
        logic [31:0] div;
        write_register(REG_CXX, random_coef(style));
        write_register(REG_CXY, random_coef(style));
        write_register(REG_OFFX, random_coef(style));
        write_register(REG_CYX, random_coef(style));
        write_register(REG_CYY, random_coef(style));
        write_register(REG_OFFY, random_coef(style));
        div = (style == 2) ? 32'hffffffff : random_coef(style);
        if (div == 0) div = 1;
        write_register(REG_DIV, div);
        write_register(REG_CALRES, {16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))});
    endtask

    initial begin : stimulus
        t_in_word w;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Divisor still zero after reset: every sample reports the zero divisor.
        w = '0;
        send_sample(w, 1'b0);
        w = '1;
        send_sample(w, 1'b0);
        drain();

        // Divisor set but calibration width, then height, zero.
        write_register(REG_DIV, 32'd1);
        write_register(REG_CALRES, 32'hffff_0000);
        send_sample(w, 1'b0);
        drain();
        write_register(REG_CALRES, 32'h0000_ffff);
        send_sample(w, 1'b0);
        drain();

        // Quotient overflow: most-negative numerator divided by minus one.
        write_register(REG_OFFX, 32'h8000_0000);
        write_register(REG_OFFY, 32'h8000_0000);
        write_register(REG_DIV, 32'hffff_ffff);
        write_register(REG_CALRES, 32'h0001_0001);
        w = '0;
        w.target_width  = 16'd1;
        w.target_height = 16'd1;
        send_sample(w, 1'b0);
        w.target_width  = 16'hffff;
        w.target_height = 16'hffff;
        w.raw_x = 12'hfff;
        w.raw_y = 12'hfff;
        send_sample(w, 1'b0);
        drain();

        // Extreme and mixed settings with random bursts.
        for (int phase = 0; phase < 12; phase++) begin
            load_setting(phase % 3);
            if (phase == 4) begin
                // Long receiver hold-off so the pipeline backs up into the input.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    send_burst(200, 1'b0);
                join
            end
            for (int b = 0; b < 8; b++)
                send_burst($urandom_range(1, 28), phase % 4 == 1);
            drain();
        end

        // A final pass back at zero divisor and zero calibration size.
        write_register(REG_DIV, 32'd0);
        send_burst(10, 1'b1);
        drain();
        write_register(REG_DIV, 32'd7);
        write_register(REG_CALRES, 32'd0);
        send_burst(10, 1'b1);
        drain();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
